FILE: design/prs_pkg.sv
// Shared types and constants for the periodic release selector.
package prs_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int TICK_W        = 32;
    localparam int INDEX_W       = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic
    {
        FUNC_LOAD   = 1'b0,
        FUNC_SELECT = 1'b1
    } func_t;

    typedef struct packed
    {
        logic load;
        logic start;
        logic issue;
        logic commit;
    } prs_cmd_t;

    typedef struct packed
    {
        logic scan_last;
        logic pipe_idle;
    } prs_status_t;

endpackage

FILE: design/prs_req_if.sv
// Request channel carrying load and select beats.
interface prs_req_if;
    import prs_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [INDEX_W-1:0]  entry_index;
    logic [TICK_W-1:0]   period_ticks;
    logic [TICK_W-1:0]   phase_ticks;
    logic [TICK_W-1:0]   deadline_ticks;
    logic [TICK_W-1:0]   now_ticks;

    modport source
    (
        output valid, func, entry_index, period_ticks, phase_ticks, deadline_ticks, now_ticks,
        input  ready
    );

    modport sink
    (
        input  valid, func, entry_index, period_ticks, phase_ticks, deadline_ticks, now_ticks,
        output ready
    );

endinterface

FILE: design/prs_rsp_if.sv
// Response channel carrying the selected release beat.
interface prs_rsp_if;
    import prs_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  chosen_index;
    logic [TICK_W-1:0]   wait_ticks;
    logic [TICK_W-1:0]   chosen_deadline;
    logic                none_valid;

    modport source
    (
        output valid, chosen_index, wait_ticks, chosen_deadline, none_valid,
        input  ready
    );

    modport sink
    (
        input  valid, chosen_index, wait_ticks, chosen_deadline, none_valid,
        output ready
    );

endinterface

FILE: design/periodic_release_selector.sv
// Periodic release selector: a load beat writes one table entry and leaves the block ready;
// a select beat feeds one table entry per cycle into a 5-stage read, multiply, saturate,
// subtract and compare pipeline, waits for the pipeline to empty, then commits one result.
// A new request is taken the cycle after the previous select has committed; a commit waits
// while the previous result is still held by a low ready.
// Reset clears all entry valid bits; table contents are undefined until loaded.
module periodic_release_selector #(
    parameter int NUM_TASKS = prs_pkg::NUM_TASKS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    prs_req_if.sink   req,
    prs_rsp_if.source rsp
);
    import prs_pkg::*;

    prs_cmd_t    cmd;
    prs_status_t status;

    prs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    prs_datapath #(
        .NUM_TASKS (NUM_TASKS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .entry_index     (req.entry_index),
        .period_ticks    (req.period_ticks),
        .phase_ticks     (req.phase_ticks),
        .deadline_ticks  (req.deadline_ticks),
        .now_ticks       (req.now_ticks),
        .chosen_index    (rsp.chosen_index),
        .wait_ticks      (rsp.wait_ticks),
        .chosen_deadline (rsp.chosen_deadline),
        .none_valid      (rsp.none_valid)
    );

endmodule

FILE: design/prs_ctrl.sv
// Control state machine that sequences loads, table scans and result commits.
module prs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_func,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output prs_pkg::prs_cmd_t     cmd,
    input  prs_pkg::prs_status_t  status
);
    import prs_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_func == FUNC_SELECT)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_idle)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_commit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.pipe_idle)
        else $error("Result committed while the scan pipeline still held entries.");

endmodule

FILE: design/prs_datapath.sv
// Task tables, release-time pipeline, earliest-wait tracker and result register.
module prs_datapath #(
    parameter int NUM_TASKS = prs_pkg::NUM_TASKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  prs_pkg::prs_cmd_t             cmd,
    output prs_pkg::prs_status_t          status,
    input  logic [prs_pkg::INDEX_W-1:0]   entry_index,
    input  logic [prs_pkg::TICK_W-1:0]    period_ticks,
    input  logic [prs_pkg::TICK_W-1:0]    phase_ticks,
    input  logic [prs_pkg::TICK_W-1:0]    deadline_ticks,
    input  logic [prs_pkg::TICK_W-1:0]    now_ticks,
    output logic [prs_pkg::INDEX_W-1:0]   chosen_index,
    output logic [prs_pkg::TICK_W-1:0]    wait_ticks,
    output logic [prs_pkg::TICK_W-1:0]    chosen_deadline,
    output logic                          none_valid
);
    import prs_pkg::*;

    localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PROD_W = 2 * TICK_W;

    logic [TICK_W-1:0]    period_mem   [NUM_TASKS];
    logic [TICK_W-1:0]    phase_mem    [NUM_TASKS];
    logic [TICK_W-1:0]    deadline_mem [NUM_TASKS];
    logic [TICK_W-1:0]    count_mem    [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;

    logic [IDX_W-1:0]  load_addr;
    logic              load_ok;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [TICK_W-1:0] now_reg;

    logic              s1_q, s2_q, s3_q, s4_q;
    logic              s1_v, s2_v, s3_v, s4_v;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [TICK_W-1:0] rd_period_reg, rd_phase_reg, rd_deadline_reg, rd_count_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TICK_W-1:0] s2_phase_reg, s2_deadline_reg, s2_count_reg;
    logic [TICK_W-1:0] s3_rel_reg, s3_deadline_reg, s3_count_reg;
    logic [TICK_W-1:0] s4_wait_reg, s4_deadline_reg, s4_count_reg;
    logic [PROD_W:0]   rel_sum;
    logic [TICK_W-1:0] rel_sat;
    logic [TICK_W-1:0] wait_next;

    logic              found_reg;
    logic              better;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TICK_W-1:0] best_wait_reg, best_deadline_reg, best_count_reg;
    logic [TICK_W-1:0] count_inc;

    assign load_addr = IDX_W'(entry_index);
    assign load_ok   = int'(entry_index) < NUM_TASKS;

    assign status.scan_last = (scan_idx_reg == IDX_W'(NUM_TASKS - 1));
    assign status.pipe_idle = !(s1_q || s2_q || s3_q || s4_q);

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            period_mem[load_addr]   <= period_ticks;
            phase_mem[load_addr]    <= phase_ticks;
            deadline_mem[load_addr] <= deadline_ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            count_mem[load_addr] <= '0;
        end
        else if (cmd.commit && found_reg)
        begin
            count_mem[best_idx_reg] <= count_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_period_reg   <= period_mem[scan_idx_reg];
        rd_phase_reg    <= phase_mem[scan_idx_reg];
        rd_deadline_reg <= deadline_mem[scan_idx_reg];
        rd_count_reg    <= count_mem[scan_idx_reg];
        s1_idx_reg      <= scan_idx_reg;
    end

    always_comb
    begin
        rel_sum   = {1'b0, prod_reg} + (PROD_W + 1)'(s2_phase_reg);
        rel_sat   = (|rel_sum[PROD_W:TICK_W]) ? TICK_MAX : rel_sum[TICK_W-1:0];
        wait_next = (s3_rel_reg > now_reg) ? (s3_rel_reg - now_reg) : '0;
        better    = s4_v && (!found_reg || (s4_wait_reg < best_wait_reg));
        count_inc = (best_count_reg == TICK_MAX) ? best_count_reg
                                                 : best_count_reg + TICK_W'(1);
    end

    always_ff @(posedge clk)
    begin
        prod_reg        <= PROD_W'(rd_period_reg) * PROD_W'(rd_count_reg);
        s2_phase_reg    <= rd_phase_reg;
        s2_deadline_reg <= rd_deadline_reg;
        s2_count_reg    <= rd_count_reg;
        s2_idx_reg      <= s1_idx_reg;

        s3_rel_reg      <= rel_sat;
        s3_deadline_reg <= s2_deadline_reg;
        s3_count_reg    <= s2_count_reg;
        s3_idx_reg      <= s2_idx_reg;

        s4_wait_reg     <= wait_next;
        s4_deadline_reg <= s3_deadline_reg;
        s4_count_reg    <= s3_count_reg;
        s4_idx_reg      <= s3_idx_reg;

        if (cmd.start)
        begin
            now_reg <= now_ticks;
        end

        if (better)
        begin
            best_idx_reg      <= s4_idx_reg;
            best_wait_reg     <= s4_wait_reg;
            best_deadline_reg <= s4_deadline_reg;
            best_count_reg    <= s4_count_reg;
        end

        if (cmd.commit)
        begin
            if (found_reg)
            begin
                chosen_index    <= INDEX_W'(best_idx_reg);
                wait_ticks      <= best_wait_reg;
                chosen_deadline <= best_deadline_reg;
                none_valid      <= 1'b0;
            end
            else
            begin
                chosen_index    <= '0;
                wait_ticks      <= '0;
                chosen_deadline <= '0;
                none_valid      <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            s1_q         <= 1'b0;
            s2_q         <= 1'b0;
            s3_q         <= 1'b0;
            s4_q         <= 1'b0;
            s1_v         <= 1'b0;
            s2_v         <= 1'b0;
            s3_v         <= 1'b0;
            s4_v         <= 1'b0;
        end
        else
        begin
            if (cmd.load && load_ok)
            begin
                valid_reg[load_addr] <= 1'b1;
            end

            if (cmd.start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end

            s1_q <= cmd.issue;
            s2_q <= s1_q;
            s3_q <= s2_q;
            s4_q <= s3_q;
            s1_v <= cmd.issue && valid_reg[scan_idx_reg];
            s2_v <= s1_v;
            s3_v <= s2_v;
            s4_v <= s3_v;
        end
    end

    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s4_q |-> $past(s3_q))
        else $error("Last scan stage filled without a beat in the stage before it.");

    a_best_is_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> valid_reg[best_idx_reg])
        else $error("Best entry tracker points at an entry that was never loaded.");

endmodule
